@@ design/mi3_pkg.sv @@
// shared constants, types and helpers for the 3x3 matrix inverse unit
package mi3_pkg;

    localparam int MATRIX_DIM   = 3;
    localparam int N_ELEM       = MATRIX_DIM * MATRIX_DIM;
    localparam int ELEM_W       = 16;
    localparam int OUT_W        = 32;
    localparam int IN_FRAC_DEF  = 8;
    localparam int OUT_FRAC_DEF = 16;
    localparam int PROD_W       = 2 * ELEM_W;        // minor product
    localparam int COF_W        = PROD_W + 1;        // cofactor, signed
    localparam int DETP_W       = COF_W + ELEM_W;    // element times cofactor
    localparam int DSUM_W       = DETP_W + 2;        // sum of three
    localparam int DMAG_W       = 48;                // |det| < 3 * 2^46
    localparam int NMAG_W       = 32;                // |cofactor| <= 2^31
    localparam int QB           = 34;                // quotient bits kept below overflow bit
    localparam int MAG64_W      = 64;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } clip_t;

    // clip a sign and magnitude pair to a signed 32-bit word
    function automatic clip_t clip32(input logic neg, input logic [MAG64_W-1:0] mag);
        clip_t r;
        r.sat = 1'b0;
        if (neg && (mag != '0))
        begin
            if (mag > 64'h0000_0000_8000_0000)
            begin
                r.sat = 1'b1;
                r.val = 32'h8000_0000;
            end
            else
            begin
                r.val = OUT_W'(~mag + 64'd1);
            end
        end
        else
        begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
            begin
                r.sat = 1'b1;
                r.val = 32'h7FFF_FFFF;
            end
            else
            begin
                r.val = mag[OUT_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

@@ design/mi3_cof_lane.sv @@
// one cofactor lane: two products of a 2x2 minor, difference, sign
module mi3_cof_lane
    import mi3_pkg::*;
(
    input  logic                     clk,
    input  logic                     ce,
    input  logic signed [ELEM_W-1:0] p,
    input  logic signed [ELEM_W-1:0] q,
    input  logic signed [ELEM_W-1:0] s,
    input  logic signed [ELEM_W-1:0] t,
    input  logic                     neg,
    output logic signed [COF_W-1:0]  cof
);

    logic signed [PROD_W-1:0] pt_reg;
    logic signed [PROD_W-1:0] qs_reg;
    logic                     neg_reg;
    logic signed [COF_W-1:0]  cof_reg;
    logic signed [COF_W-1:0]  diff;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pt_reg  <= p * t;
            qs_reg  <= q * s;
            neg_reg <= neg;
            cof_reg <= neg_reg ? -diff : diff;
        end
    end

    assign diff = COF_W'(pt_reg) - COF_W'(qs_reg);
    assign cof  = cof_reg;

endmodule

@@ design/mi3_div_lane.sv @@
// pipelined restoring divider lane, one quotient bit per stage, round and clip
module mi3_div_lane
    import mi3_pkg::*;
#(
    parameter int SHIFT_BITS = IN_FRAC_DEF + OUT_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              ce,
    input  logic [NMAG_W-1:0] nmag,
    input  logic [DMAG_W-1:0] dmag,
    input  logic              neg,
    output logic [OUT_W-1:0]  quo,
    output logic              sat
);

    localparam int RW = DMAG_W + QB + 2;
    localparam int ST = QB + 1;

    logic [RW-1:0]     rem_reg [0:ST-1];
    logic [ST-1:0]     q_reg   [0:ST-1];
    logic [DMAG_W-1:0] d_reg   [0:ST-1];
    logic              neg_reg [0:ST-1];
    logic [RW-1:0]     rem0;
    logic [OUT_W-1:0]  quo_reg;
    logic              sat_reg;

    // numerator carries one extra bit for the rounding decision
    assign rem0 = RW'(nmag) << (SHIFT_BITS + 1);

    for (genvar i = 0; i < ST; i++)
    begin : g_stage
        logic [RW-1:0]     rin;
        logic [ST-1:0]     qin;
        logic [DMAG_W-1:0] din;
        logic              nin;
        logic [RW-1:0]     dsh;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign rin = rem0;
            assign qin = '0;
            assign din = dmag;
            assign nin = neg;
        end
        else
        begin : g_rest
            assign rin = rem_reg[i-1];
            assign qin = q_reg[i-1];
            assign din = d_reg[i-1];
            assign nin = neg_reg[i-1];
        end

        assign dsh = RW'(din) << (QB - i);
        assign ge  = (rin >= dsh);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i] <= ge ? (rin - dsh) : rin;
                q_reg[i]   <= {qin[ST-2:0], ge};
                d_reg[i]   <= din;
                neg_reg[i] <= nin;
            end
        end
    end

    logic              ovf;
    logic [QB:0]       qsum;
    logic [QB-1:0]     qr;
    logic [MAG64_W-1:0] mag;
    clip_t             clipped;

    assign ovf     = q_reg[ST-1][QB];
    assign qsum    = {1'b0, q_reg[ST-1][QB-1:0]} + (QB+1)'(1);
    assign qr      = qsum[QB:1];
    assign mag     = ovf ? {MAG64_W{1'b1}} : MAG64_W'(qr);
    assign clipped = clip32(neg_reg[ST-1], mag);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quo_reg <= clipped.val;
            sat_reg <= clipped.sat;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

@@ design/matrix_inverse_3x3_unit.sv @@
// 3x3 matrix inverse by the adjugate, nine cofactor and nine divider lanes
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid, s_tready | s_tdata: a00..a22, 16b signed each
//  m_      | out | m_tvalid, m_tready | m_tdata: inv00..inv22, determinant (32b)
//          |     |                    | m_tuser: singular, saturated
//
//  one matrix accepted per cycle; stages: minor products, cofactors, det products,
//  divider operands, 35 divider stages (one quotient bit each), round/clip, merge
//  the whole pipeline moves together; it holds while an output word waits unread
//  asynchronous active-low reset clears only the valid line, no clearing pass
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int IN_FRAC_BITS  = IN_FRAC_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // inv00..inv22, determinant
    output logic [1:0]   m_tuser    // singular, saturated
);

    localparam int SHIFT_BITS = IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam int DET_SH     = 3 * IN_FRAC_BITS - OUT_FRAC_BITS;
    localparam int DIV_LAT    = QB + 2;
    localparam int LAT        = 4 + DIV_LAT + 1;
    localparam int IN_W       = N_ELEM * ELEM_W;

    // global advance: the pipeline moves unless a finished word is stuck
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // valid line, one bit per stage
    logic [LAT-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[LAT-2:0], s_tvalid};
        end
    end

    // raw elements travel alongside for the determinant products and the singular echo
    logic [IN_W-1:0] el_reg [0:LAT-2];
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            el_reg[0] <= s_tdata;
            for (int k = 1; k < LAT - 1; k++)
            begin
                el_reg[k] <= el_reg[k-1];
            end
        end
    end

    // cofactor lanes: lane r*3+c gives the signed cofactor C[r][c]
    logic signed [COF_W-1:0] cof_b [0:N_ELEM-1];
    for (genvar r = 0; r < MATRIX_DIM; r++)
    begin : g_row
        for (genvar c = 0; c < MATRIX_DIM; c++)
        begin : g_col
            localparam int R0 = (r == 0) ? 1 : 0;
            localparam int R1 = (r == 2) ? 1 : 2;
            localparam int C0 = (c == 0) ? 1 : 0;
            localparam int C1 = (c == 2) ? 1 : 2;
            mi3_cof_lane u_cof (
                .clk (clk),
                .ce  (ce),
                .p   ($signed(s_tdata[ELEM_W*(R0*MATRIX_DIM+C0) +: ELEM_W])),
                .q   ($signed(s_tdata[ELEM_W*(R0*MATRIX_DIM+C1) +: ELEM_W])),
                .s   ($signed(s_tdata[ELEM_W*(R1*MATRIX_DIM+C0) +: ELEM_W])),
                .t   ($signed(s_tdata[ELEM_W*(R1*MATRIX_DIM+C1) +: ELEM_W])),
                .neg (((r + c) % 2) == 1),
                .cof (cof_b[r*MATRIX_DIM+c])
            );
        end
    end

    // determinant by expansion along row 0, equal to the rule of Sarrus
    logic signed [COF_W-1:0]  cof_c_reg  [0:N_ELEM-1];
    logic signed [DETP_W-1:0] detp_reg   [0:MATRIX_DIM-1];
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                cof_c_reg[k] <= cof_b[k];
            end
            for (int j = 0; j < MATRIX_DIM; j++)
            begin
                detp_reg[j] <= $signed(el_reg[1][ELEM_W*j +: ELEM_W]) * cof_b[j];
            end
        end
    end

    logic signed [DSUM_W-1:0] dsum;
    logic                     dneg;
    logic [DMAG_W-1:0]        dmag;
    assign dsum = DSUM_W'(detp_reg[0]) + DSUM_W'(detp_reg[1]) + DSUM_W'(detp_reg[2]);
    assign dneg = dsum[DSUM_W-1];
    assign dmag = dneg ? DMAG_W'(-dsum) : DMAG_W'(dsum);

    // divider operands, numerators taken from the transposed cofactors
    logic [NMAG_W-1:0] nmag_reg [0:N_ELEM-1];
    logic              nneg_reg [0:N_ELEM-1];
    logic [DMAG_W-1:0] dmag_reg [0:DIV_LAT];
    logic              dneg_reg [0:DIV_LAT];
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < MATRIX_DIM; i++)
            begin
                for (int j = 0; j < MATRIX_DIM; j++)
                begin
                    nmag_reg[i*MATRIX_DIM+j] <= cof_c_reg[j*MATRIX_DIM+i][COF_W-1]
                        ? NMAG_W'(-cof_c_reg[j*MATRIX_DIM+i])
                        : NMAG_W'(cof_c_reg[j*MATRIX_DIM+i]);
                    nneg_reg[i*MATRIX_DIM+j] <= cof_c_reg[j*MATRIX_DIM+i][COF_W-1] ^ dneg;
                end
            end
            dmag_reg[0] <= dmag;
            dneg_reg[0] <= dneg;
            for (int k = 1; k <= DIV_LAT; k++)
            begin
                dmag_reg[k] <= dmag_reg[k-1];
                dneg_reg[k] <= dneg_reg[k-1];
            end
        end
    end

    logic [OUT_W-1:0] quo [0:N_ELEM-1];
    logic [N_ELEM-1:0] qsat;
    for (genvar k = 0; k < N_ELEM; k++)
    begin : g_div
        mi3_div_lane #(
            .SHIFT_BITS (SHIFT_BITS)
        ) u_div (
            .clk  (clk),
            .ce   (ce),
            .nmag (nmag_reg[k]),
            .dmag (dmag_reg[0]),
            .neg  (nneg_reg[k]),
            .quo  (quo[k]),
            .sat  (qsat[k])
        );
    end

    // determinant rescale, round half away from zero on the magnitude
    logic [MAG64_W-1:0] dm64;
    logic [MAG64_W-1:0] dscaled;
    assign dm64 = MAG64_W'(dmag_reg[DIV_LAT]);
    if (DET_SH > 0)
    begin : g_det_down
        assign dscaled = (dm64 + (MAG64_W'(1) << (DET_SH - 1))) >> DET_SH;
    end
    else if (DET_SH < 0)
    begin : g_det_up
        assign dscaled = dm64 << (-DET_SH);
    end
    else
    begin : g_det_same
        assign dscaled = dm64;
    end

    clip_t det_clip;
    logic  singular;
    assign det_clip = clip32(dneg_reg[DIV_LAT], dscaled);
    assign singular = (dmag_reg[DIV_LAT] == '0);

    // merge: pick quotients or the echoed input, gather the flags
    logic [319:0] data_reg;
    logic [1:0]   user_reg;
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                data_reg[OUT_W*k +: OUT_W] <= singular
                    ? OUT_W'($signed(el_reg[LAT-2][ELEM_W*k +: ELEM_W]))
                    : quo[k];
            end
            data_reg[OUT_W*N_ELEM +: OUT_W] <= singular ? '0 : det_clip.val;
            user_reg[0] <= singular;
            user_reg[1] <= !singular && ((|qsat) || det_clip.sat);
        end
    end

    assign m_tvalid = v_reg[LAT-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    // a singular word never reports clipping
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
        else $error("singular word flagged saturated");

    // a singular word carries a zero determinant
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[319:288] == '0))
        else $error("singular word with nonzero determinant");

    // a stuck output word holds the whole pipeline, input included
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

endmodule
